[rtl/core/rgfwg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgfwg_pkg: shared types and constants of the random grid fill core
// Sequencer states, configuration register indexes, field widths and the
// xorshift32 step used for every draw.
// ----------------------------------------------------------------------------
package rgfwg_pkg;

    localparam int MAX_SIDE_DEF = 126;
    localparam int ADDR_W       = 21;
    localparam int VAL_W        = 8;
    localparam int SIDE_W       = 7;
    localparam int DENS_W       = 33;
    localparam int CFG_IDX_W    = 2;

    localparam logic [31:0] SEED_OFFSET = 32'd987654321;
    localparam logic [31:0] SIGN_FLIP   = 32'h8000_0000;

    localparam logic [CFG_IDX_W-1:0] CFG_SEED    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENSITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIES = 2'd3;

    localparam logic [SIDE_W-1:0] SIDE_RST    = 7'd2;
    localparam logic [VAL_W-1:0]  SPECIES_RST = 8'd9;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PAD3,
        S_ZTERM,
        S_YTERM,
        S_SPEC,
        S_EMIT
    } t_state;

    // one xorshift32 step: shift left 13, right 17, left 5
    function automatic logic [31:0] xs32_next(input logic [31:0] s);
        logic [31:0] t;
        t = s ^ (s << 13);
        t = t ^ (t >> 17);
        t = t ^ (t << 5);
        return t;
    endfunction

endpackage

[rtl/core/random_grid_fill_with_wrap_ghosts_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_grid_fill_with_wrap_ghosts_core: random cube fill with wrap ghosts
// Fills the interior of a padded cube one cell per input word and emits the
// cell write plus its toroidal ghost copies as a stream of write words.
// ----------------------------------------------------------------------------
// Each accepted input word handles one interior cell of a cube of side N
// padded to P = N + 2, visiting x fastest, then y, then z. A word with
// restart set reloads the xorshift32 state with seed + 987654321 and moves
// the cursor to (1,1,1) first. A live draw (fraction below density) is
// followed by a species draw floor(u*K)+1; a dead cell writes 0. The block
// emits the cell's own write, then one ghost write for every nonempty subset
// of the axes on which the cell touches the border (1, 2, 4 or 8 words in
// all), tlast on the final one. Once the fill is complete, each input word
// gives one word with tuser write_valid clear, tuser done set and tlast set.
// Timing: the write words of a cell leave one per cycle while the output is
// not stalled, and a new input word is taken only after the cell's last
// word has been issued. The pace is set by the single shared multiplier,
// which makes five passes per cell (P*P, P*P*P, z*P*P, y*P and u*K), and by
// the single output register.
// ----------------------------------------------------------------------------
module random_grid_fill_with_wrap_ghosts_core
    import rgfwg_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DENS_W-1:0]    i_cfg_data,
    // input stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [7:0]           s_axis_tdata,   // [0] restart, [7:1] zero
    // output stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata,   // [20:0] write_address,
                                                 // [28:21] write_value, [31:29] zero
    output logic                 m_axis_tlast,   // last word of this cell
    output logic [1:0]           m_axis_tuser    // [0] write_valid, [1] done_res
);

    // cursor and pad width, operand width of the shared multiplier
    localparam int PW    = $clog2(MAX_SIDE + 3);
    localparam int BW    = (PW > VAL_W) ? PW : VAL_W;
    localparam int SW    = (PW > SIDE_W) ? PW : SIDE_W;
    localparam int PROD_W = 32 + BW;

    t_state r_state, n_state;

    // configuration registers
    logic [31:0]        r_seed,    n_seed;
    logic [DENS_W-1:0]  r_density, n_density;
    logic [SIDE_W-1:0]  r_side,    n_side;
    logic [VAL_W-1:0]   r_kinds,   n_kinds;

    // fill state
    logic [31:0]        r_rng, n_rng;
    logic [PW-1:0]      r_cx, n_cx, r_cy, n_cy, r_cz, n_cz;
    logic               r_finished, n_finished;

    // per-cell working registers
    logic               r_live, n_live;
    logic [31:0]        r_frac, n_frac;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [ADDR_W-1:0]  r_pad2, n_pad2, r_pad3, n_pad3;
    logic [ADDR_W-1:0]  r_zt, n_zt, r_yt, n_yt, r_zgt, n_zgt, r_ygt, n_ygt;
    logic [2:0]         r_bmask, n_bmask, r_mask, n_mask;
    logic               r_done_tick, n_done_tick;
    logic               r_fin_word, n_fin_word;

    // output register
    logic               r_m_valid, n_m_valid;
    logic [ADDR_W-1:0]  r_m_addr, n_m_addr;
    logic [VAL_W-1:0]   r_m_val, n_m_val;
    logic               r_m_last, n_m_last, r_m_wv, n_m_wv, r_m_done, n_m_done;

    // shared multiplier
    logic [31:0]        w_mul_a;
    logic [BW-1:0]      w_mul_b;
    logic [PROD_W-1:0]  w_prod;

    logic [SW-1:0]      w_side_ext, w_n_sat;
    logic [PW-1:0]      w_n, w_pad;
    logic [31:0]        w_rng_nx, w_frac;
    logic               w_invalid, w_out_free;
    logic               w_bx, w_by, w_bz;
    logic [ADDR_W-1:0]  w_xsel, w_ysel, w_zsel, w_addr;

    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // saturate N to MAX_SIDE, P = N + 2
    assign w_side_ext = SW'(r_side);
    assign w_n_sat    = (w_side_ext > SW'(MAX_SIDE)) ? SW'(MAX_SIDE) : w_side_ext;
    assign w_n        = PW'(w_n_sat);
    assign w_pad      = w_n + PW'(2);

    // draw: fraction is the wrapped sum of old and new state, sign flipped
    assign w_rng_nx = xs32_next(r_rng);
    assign w_frac   = (r_rng + w_rng_nx) ^ SIGN_FLIP;

    assign w_invalid = r_finished || (w_n == '0) ||
                       (r_cx > w_n) || (r_cy > w_n) || (r_cz > w_n) ||
                       (r_cx == '0) || (r_cy == '0) || (r_cz == '0);

    assign w_bx = (r_cx == PW'(1)) || (r_cx == w_n);
    assign w_by = (r_cy == PW'(1)) || (r_cy == w_n);
    assign w_bz = (r_cz == PW'(1)) || (r_cz == w_n);

    // address = z-term + y-term + x, each taken from the cell or its ghost
    assign w_xsel = r_mask[0] ? ((r_cx == PW'(1)) ? ADDR_W'(w_pad - PW'(1)) : '0)
                              : ADDR_W'(r_cx);
    assign w_ysel = r_mask[1] ? r_ygt : r_yt;
    assign w_zsel = r_mask[2] ? r_zgt : r_zt;
    assign w_addr = w_zsel + w_ysel + w_xsel;

    assign w_out_free = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_seed      = r_seed;
        n_density   = r_density;
        n_side      = r_side;
        n_kinds     = r_kinds;
        n_rng       = r_rng;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_finished  = r_finished;
        n_live      = r_live;
        n_frac      = r_frac;
        n_val       = r_val;
        n_pad2      = r_pad2;
        n_pad3      = r_pad3;
        n_zt        = r_zt;
        n_yt        = r_yt;
        n_zgt       = r_zgt;
        n_ygt       = r_ygt;
        n_bmask     = r_bmask;
        n_mask      = r_mask;
        n_done_tick = r_done_tick;
        n_fin_word  = r_fin_word;
        n_m_valid   = r_m_valid;
        n_m_addr    = r_m_addr;
        n_m_val     = r_m_val;
        n_m_last    = r_m_last;
        n_m_wv      = r_m_wv;
        n_m_done    = r_m_done;
        w_mul_a     = '0;
        w_mul_b     = '0;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEED:    n_seed    = i_cfg_data[31:0];
                CFG_DENSITY: n_density = i_cfg_data;
                CFG_SIDE:    n_side    = i_cfg_data[SIDE_W-1:0];
                CFG_SPECIES: n_kinds   = i_cfg_data[VAL_W-1:0];
                default: ;
            endcase
        end

        // drop the output word once taken
        if (r_m_valid && m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    if (s_axis_tdata[0]) begin
                        n_rng      = r_seed + SEED_OFFSET;
                        n_cx       = PW'(1);
                        n_cy       = PW'(1);
                        n_cz       = PW'(1);
                        n_finished = 1'b0;
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_fin_word = w_invalid;
                if (w_invalid) begin
                    n_finished = 1'b1;
                    n_state    = S_EMIT;
                end else begin
                    n_rng       = w_rng_nx;
                    n_live      = {1'b0, w_frac} < r_density;
                    w_mul_a     = 32'(w_pad);
                    w_mul_b     = BW'(w_pad);
                    n_pad2      = w_prod[ADDR_W-1:0];
                    n_bmask     = {w_bz, w_by, w_bx};
                    n_mask      = 3'b000;
                    n_done_tick = (r_cx == w_n) && (r_cy == w_n) && (r_cz == w_n);
                    n_state     = S_PAD3;
                end
            end
            S_PAD3: begin
                w_mul_a = 32'(r_pad2);
                w_mul_b = BW'(w_pad);
                n_pad3  = w_prod[ADDR_W-1:0];
                // second draw only for a live cell
                if (r_live) begin
                    n_rng  = w_rng_nx;
                    n_frac = w_frac;
                end
                n_state = S_ZTERM;
            end
            S_ZTERM: begin
                w_mul_a = 32'(r_pad2);
                w_mul_b = BW'(r_cz);
                n_zt    = w_prod[ADDR_W-1:0];
                n_zgt   = (r_cz == PW'(1)) ? (r_pad3 - r_pad2) : '0;
                n_state = S_YTERM;
            end
            S_YTERM: begin
                w_mul_a = 32'(w_pad);
                w_mul_b = BW'(r_cy);
                n_yt    = w_prod[ADDR_W-1:0];
                n_ygt   = (r_cy == PW'(1)) ? (r_pad2 - ADDR_W'(w_pad)) : '0;
                n_state = S_SPEC;
            end
            S_SPEC: begin
                w_mul_a = r_frac;
                w_mul_b = BW'(r_kinds);
                n_val   = r_live ? (w_prod[32 +: VAL_W] + VAL_W'(1)) : '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_m_valid = 1'b1;
                    if (r_fin_word) begin
                        n_m_wv   = 1'b0;
                        n_m_addr = '0;
                        n_m_val  = '0;
                        n_m_last = 1'b1;
                        n_m_done = 1'b1;
                        n_state  = S_IDLE;
                    end else begin
                        n_m_wv   = 1'b1;
                        n_m_addr = w_addr;
                        n_m_val  = r_val;
                        n_m_last = (r_mask == r_bmask);
                        n_m_done = r_done_tick;
                        if (r_mask == r_bmask) begin
                            // advance the cursor, x fastest
                            if (r_cx == w_n) begin
                                n_cx = PW'(1);
                                if (r_cy == w_n) begin
                                    n_cy = PW'(1);
                                    if (r_cz == w_n) begin
                                        n_cz = PW'(1);
                                    end else begin
                                        n_cz = r_cz + PW'(1);
                                    end
                                end else begin
                                    n_cy = r_cy + PW'(1);
                                end
                            end else begin
                                n_cx = r_cx + PW'(1);
                            end
                            if (r_done_tick) begin
                                n_finished = 1'b1;
                            end
                            n_state = S_IDLE;
                        end else begin
                            // next subset of the border axes in counting order
                            n_mask = ((r_mask | ~r_bmask) + 3'b001) & r_bmask;
                        end
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed     <= '0;
            r_density  <= '0;
            r_side     <= SIDE_RST;
            r_kinds    <= SPECIES_RST;
            r_rng      <= '0;
            r_cx       <= PW'(1);
            r_cy       <= PW'(1);
            r_cz       <= PW'(1);
            r_finished <= 1'b0;
            r_m_valid  <= 1'b0;
        end else begin
            r_seed     <= n_seed;
            r_density  <= n_density;
            r_side     <= n_side;
            r_kinds    <= n_kinds;
            r_rng      <= n_rng;
            r_cx       <= n_cx;
            r_cy       <= n_cy;
            r_cz       <= n_cz;
            r_finished <= n_finished;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_live      <= n_live;
        r_frac      <= n_frac;
        r_val       <= n_val;
        r_pad2      <= n_pad2;
        r_pad3      <= n_pad3;
        r_zt        <= n_zt;
        r_yt        <= n_yt;
        r_zgt       <= n_zgt;
        r_ygt       <= n_ygt;
        r_bmask     <= n_bmask;
        r_mask      <= n_mask;
        r_done_tick <= n_done_tick;
        r_fin_word  <= n_fin_word;
        r_m_addr    <= n_m_addr;
        r_m_val     <= n_m_val;
        r_m_last    <= n_m_last;
        r_m_wv      <= n_m_wv;
        r_m_done    <= n_m_done;
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_m_val, r_m_addr};
    assign m_axis_tlast  = r_m_last;
    assign m_axis_tuser  = {r_m_done, r_m_wv};

    // one cell at a time: no new word right after one is taken
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while a cell is in progress");

    // a word without a write is only the completed-grid report
    a_nowrite_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |->
        (m_axis_tlast && m_axis_tuser[1] && (m_axis_tdata == 32'd0)))
        else $error("non-write word is not a done report");

    // ghost selection never leaves the border axes of the cell
    a_mask_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_fin_word) |-> ((r_mask & ~r_bmask) == 3'b000))
        else $error("ghost mask outside border set");

    // writes come only from a cursor inside the cube
    a_cursor_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && !r_fin_word) |->
        ((r_cx != '0) && (r_cy != '0) && (r_cz != '0) &&
         (r_cx <= w_n) && (r_cy <= w_n) && (r_cz <= w_n)))
        else $error("write from a cursor outside the cube");

    // a taken word without tlast is followed straight away by the next word
    a_more_after_nonlast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> m_axis_tvalid)
        else $error("cell ended without a last word");

endmodule
